// ===== rtl/core/dia_pkg.sv =====
// Shared types, constants and coefficient tables for the Dawson integral block.
// No dependencies; imported by dia_lane and dawson_integral_approx.
package dia_pkg;

    typedef logic signed [55:0] t_acc;

    typedef enum logic [1:0] {
        RGN_INNER,
        RGN_MIDDLE,
        RGN_OUTER
    } t_region;

    localparam int RCP_BITS     = 32;
    localparam int QUO_BITS     = 52;
    localparam int ACC_BITS     = 56;
    localparam int HORNER_STEPS = 10;
    localparam int COEF_CNT     = HORNER_STEPS + 1;

    // input reg, reciprocal, square, variable, horner, prep, quotient, round, 3 tail
    localparam int LANE_LAT = 1 + RCP_BITS + 2 + 2 * HORNER_STEPS + 1 + QUO_BITS + 4;

    localparam logic [31:0] LIM_INNER    = 32'd27262976;
    localparam logic [31:0] LIM_MIDDLE   = 32'd52428800;
    localparam logic [31:0] RCP_REM_INIT = 32'h0080_0000;
    localparam logic [30:0] OUT_MAX      = 31'h3FFF_FFFF;

    // decimal mantissa * 10^-dexp held as round(value * 2^g)
    function automatic t_acc fixed_coef(input longint man, input int dexp, input int g);
        logic        neg;
        logic [63:0] x;
        int          p;
        neg = (man < 0);
        x   = neg ? 64'(-man) : 64'(man);
        p   = g;
        if (x == 64'd0) begin
            return '0;
        end
        for (int i = 0; i < dexp; i++) begin
            for (int j = 0; j < 64; j++) begin
                if (x < 64'h0800_0000_0000_0000) begin
                    x = x << 1;
                    p = p - 1;
                end
            end
            x = x / 64'd10;
        end
        if (p < 0) begin
            if (-p >= 63) begin
                x = 64'd0;
            end else begin
                x = (x + (64'd1 << (-p - 1))) >> (-p);
            end
        end else begin
            for (int j = 0; j < 64; j++) begin
                if (p > 0) begin
                    x = x << 1;
                    p = p - 1;
                end
            end
        end
        return neg ? -t_acc'(x) : t_acc'(x);
    endfunction

    localparam t_acc NUM_TAB [0:2][0:COEF_CNT-1] = '{
        '{fixed_coef(64'sd1000000000, 9, 40), fixed_coef(-64'sd9174803718, 11, 44),
          fixed_coef(64'sd4226182230, 11, 48), fixed_coef(-64'sd8501498467, 13, 52),
          fixed_coef(64'sd3525133685, 13, 56), fixed_coef(64'sd3078283099, 15, 60),
          fixed_coef(64'sd9531517413, 16, 64), fixed_coef(64'sd1944342042, 17, 68),
          fixed_coef(64'sd8492622677, 19, 72), fixed_coef(64'sd1136814990, 20, 76),
          t_acc'(0)},
        '{fixed_coef(64'sd3592333854, 20, 64), fixed_coef(-64'sd2402745208, 18, 61),
          fixed_coef(64'sd9100107801, 17, 58), fixed_coef(-64'sd2146403517, 15, 55),
          fixed_coef(64'sd3596413048, 14, 52), fixed_coef(-64'sd4232091145, 13, 49),
          fixed_coef(64'sd3662076123, 12, 46), fixed_coef(-64'sd2187112551, 11, 43),
          fixed_coef(64'sd9415123353, 11, 40), fixed_coef(-64'sd2447544181, 10, 37),
          fixed_coef(64'sd5089551564, 10, 34)},
        '{fixed_coef(-64'sd4868276130, 13, 48), fixed_coef(64'sd1648370478, 11, 43),
          fixed_coef(-64'sd1728589754, 10, 38), fixed_coef(64'sd6292352427, 10, 33),
          fixed_coef(-64'sd5905928605, 10, 28), t_acc'(0), t_acc'(0), t_acc'(0),
          t_acc'(0), t_acc'(0), t_acc'(0)}
    };

    localparam t_acc DEN_TAB [0:2][0:COEF_CNT-1] = '{
        '{fixed_coef(64'sd1000000000, 9, 40), fixed_coef(64'sd5749186295, 10, 44),
          fixed_coef(64'sd1588742420, 10, 48), fixed_coef(64'sd2794485312, 11, 52),
          fixed_coef(64'sd3488058147, 12, 56), fixed_coef(64'sd3255247418, 13, 60),
          fixed_coef(64'sd2324902498, 14, 64), fixed_coef(64'sd1272584783, 15, 68),
          fixed_coef(64'sd5212652810, 17, 72), fixed_coef(64'sd1488646814, 18, 76),
          fixed_coef(64'sd2403720731, 20, 80)},
        '{fixed_coef(64'sd7184664032, 20, 64), fixed_coef(-64'sd4913246913, 18, 61),
          fixed_coef(64'sd1891003581, 16, 58), fixed_coef(-64'sd4558751533, 15, 55),
          fixed_coef(64'sd7810255929, 14, 52), fixed_coef(-64'sd9479967685, 13, 49),
          fixed_coef(64'sd8480417186, 12, 46), fixed_coef(-64'sd5318063670, 11, 43),
          fixed_coef(64'sd2367067882, 10, 40), fixed_coef(-64'sd6318398699, 10, 37),
          fixed_coef(64'sd1000000000, 9, 34)},
        '{fixed_coef(-64'sd9736552260, 13, 48), fixed_coef(64'sd3442789240, 11, 43),
          fixed_coef(-64'sd3937085823, 10, 38), fixed_coef(64'sd1732707990, 9, 33),
          fixed_coef(-64'sd2698200572, 9, 28), fixed_coef(64'sd1000000000, 9, 23),
          t_acc'(0), t_acc'(0), t_acc'(0), t_acc'(0), t_acc'(0)}
    };

    function automatic t_acc num_coef(input t_region rg, input int k);
        case (rg)
            RGN_INNER:  return NUM_TAB[0][k];
            RGN_MIDDLE: return NUM_TAB[1][k];
            RGN_OUTER:  return NUM_TAB[2][k];
            default:    return '0;
        endcase
    endfunction

    function automatic t_acc den_coef(input t_region rg, input int k);
        case (rg)
            RGN_INNER:  return DEN_TAB[0][k];
            RGN_MIDDLE: return DEN_TAB[1][k];
            RGN_OUTER:  return DEN_TAB[2][k];
            default:    return '0;
        endcase
    endfunction

endpackage

// ===== rtl/core/dawson_integral_approx.sv =====
// Top level of the Dawson integral block: lane array and output merge stage.
// Depends on dia_pkg and dia_lane (which uses dia_divider).
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------------
//  input   | i_arg_lane0..3 (s32, Q8.23)             | start high, busy low
//  output  | o_value_lane0..3 (s31, Q0.30, saturated)| o_strobe, one cycle
//
// A new item is taken every cycle; busy never rises. Each item's results
// pass the lane input register (loaded at the accepting edge) and the lane
// pipeline in step with r_vld, then load into the output registers and are
// taken at the edge after. Latency is set by the two bit-per-stage dividers
// (32 stages for 1/x, 52 for the rational quotient) and the 20-stage Horner
// pipeline. Reset clears only the strobe pipeline; data flows regardless and
// is qualified by it. The receiver takes every result in its one strobe cycle.
module dawson_integral_approx #(
    parameter int LANES = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_arg_lane0,
    input  logic signed [31:0] i_arg_lane1,
    input  logic signed [31:0] i_arg_lane2,
    input  logic signed [31:0] i_arg_lane3,
    output logic               o_strobe,
    output logic signed [30:0] o_value_lane0,
    output logic signed [30:0] o_value_lane1,
    output logic signed [30:0] o_value_lane2,
    output logic signed [30:0] o_value_lane3
);
    import dia_pkg::*;

    localparam int PORT_LANES = 4;

    logic               w_accept;
    logic signed [31:0] w_arg   [PORT_LANES];
    logic signed [30:0] w_val   [PORT_LANES];
    logic signed [30:0] r_value [PORT_LANES];
    logic [LANE_LAT-1:0] r_vld;
    logic                r_strobe;

    // no back-pressure anywhere: the pipeline takes an item every cycle
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_arg[0] = i_arg_lane0;
    assign w_arg[1] = i_arg_lane1;
    assign w_arg[2] = i_arg_lane2;
    assign w_arg[3] = i_arg_lane3;

    // lanes beyond LANES are not built and read as zero
    for (genvar i = 0; i < PORT_LANES; i++) begin : g_lane
        if (i < LANES) begin : g_on
            dia_lane u_lane (
                .i_clk   (i_clk),
                .i_arg   (w_arg[i]),
                .o_value (w_val[i])
            );
        end else begin : g_off
            assign w_val[i] = '0;
        end

        // merge stage: each lane lands in its own output register
        always_ff @(posedge i_clk) begin
            r_value[i] <= w_val[i];
        end
    end

    // item tracking alongside the lane pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[LANE_LAT-2:0], w_accept};
            r_strobe <= r_vld[LANE_LAT-1];
        end
    end

    assign o_strobe      = r_strobe;
    assign o_value_lane0 = r_value[0];
    assign o_value_lane1 = r_value[1];
    assign o_value_lane2 = r_value[2];
    assign o_value_lane3 = r_value[3];

endmodule

// ===== rtl/core/dia_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a carried sideband.
// No package dependency; used by dia_lane.
module dia_divider #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_feed,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quo  [QW];
    logic [QW-1:0] r_feed [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic [DW-1:0] p_rem;
        logic [QW-1:0] p_quo;
        logic [QW-1:0] p_feed;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (s == 0) begin : g_first
            assign p_rem  = i_rem;
            assign p_quo  = '0;
            assign p_feed = i_feed;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[s-1];
            assign p_quo  = r_quo[s-1];
            assign p_feed = r_feed[s-1];
            assign p_den  = r_den[s-1];
            assign p_side = r_side[s-1];
        end

        assign trial = {p_rem, p_feed[QW-1-s]};
        assign diff  = trial - {1'b0, p_den};
        assign ge    = (trial >= {1'b0, p_den});

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_quo[s]  <= {p_quo[QW-2:0], ge};
            r_feed[s] <= p_feed;
            r_den[s]  <= p_den;
            r_side[s] <= p_side;
        end
    end

    assign o_quo  = r_quo[QW-1];
    assign o_rem  = r_rem[QW-1];
    assign o_den  = r_den[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ===== rtl/core/dia_lane.sv =====
// One lane of the Dawson integral pipeline: reciprocal, square, Horner pair,
// quotient and final scaling. Depends on dia_pkg and dia_divider.
module dia_lane (
    input  logic               i_clk,
    input  logic signed [31:0] i_arg,
    output logic signed [30:0] o_value
);
    import dia_pkg::*;

    typedef struct packed {
        logic        neg;
        t_region     rgn;
        logic [31:0] mag;
        logic [31:0] r;
        logic [31:0] w;
    } t_side;

    typedef struct packed {
        t_side s;
        logic  qneg;
        logic  cap;
        logic  capneg;
    } t_qside;

    // |a| * v split into two partial products, then rounded, signed, plus coefficient
    function automatic t_acc q32_finish(input logic [55:0] hi, input logic [63:0] lo,
                                        input logic neg, input t_acc coef);
        logic [64:0] lo_r;
        logic [55:0] m;
        t_acc        val;
        lo_r = {1'b0, lo} + 65'h0_8000_0000;
        m    = hi + 56'(lo_r[64:32]);
        val  = neg ? -t_acc'(m) : t_acc'(m);
        return val + coef;
    endfunction

    function automatic logic [55:0] acc_abs(input t_acc a);
        return a[ACC_BITS-1] ? 56'(-a) : 56'(a);
    endfunction

    // input register
    logic [31:0] w_mag;
    t_region     w_rgn;
    t_side       r_st1;

    assign w_mag = i_arg[31] ? (~i_arg + 32'd1) : i_arg;

    always_comb begin
        if (w_mag < LIM_INNER) begin
            w_rgn = RGN_INNER;
        end else if (w_mag < LIM_MIDDLE) begin
            w_rgn = RGN_MIDDLE;
        end else begin
            w_rgn = RGN_OUTER;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st1 <= '{neg: i_arg[31], rgn: w_rgn, mag: w_mag, r: 32'd0, w: 32'd0};
    end

    // 1/x in Q32: (2^55 + mag/2) / mag
    logic [31:0] w_rcp_q;
    t_side       w_rcp_side;

    dia_divider #(
        .DW(32),
        .QW(RCP_BITS),
        .SW($bits(t_side))
    ) u_rcp (
        .i_clk  (i_clk),
        .i_rem  (RCP_REM_INIT),
        .i_feed ({1'b0, r_st1.mag[31:1]}),
        .i_den  (r_st1.mag),
        .i_side (r_st1),
        .o_quo  (w_rcp_q),
        .o_rem  (),
        .o_den  (),
        .o_side (w_rcp_side)
    );

    // shared squarer: mag in the inner interval, r otherwise
    logic [31:0] w_sq_a;
    logic [63:0] r_sq;
    t_side       r_sq_side;

    assign w_sq_a = (w_rcp_side.rgn == RGN_INNER) ? w_rcp_side.mag : w_rcp_q;

    always_ff @(posedge i_clk) begin
        r_sq      <= w_sq_a * w_sq_a;
        r_sq_side <= '{neg: w_rcp_side.neg, rgn: w_rcp_side.rgn, mag: w_rcp_side.mag,
                       r: w_rcp_q, w: w_rcp_side.w};
    end

    // polynomial variable and w
    logic [64:0] w_sum_in;
    logic [64:0] w_sum_mid;
    logic [64:0] w_sum_out;
    logic [64:0] w_sum_w;
    logic [31:0] w_v;
    logic [31:0] r_v;
    t_side       r_v_side;

    assign w_sum_in  = {1'b0, r_sq} + 65'h0_0002_0000;
    assign w_sum_mid = {1'b0, r_sq} + 65'h0_1000_0000;
    assign w_sum_out = {1'b0, r_sq} + 65'h0_0400_0000;
    assign w_sum_w   = {1'b0, r_sq} + 65'h0_8000_0000;

    always_comb begin
        case (r_sq_side.rgn)
            RGN_INNER:  w_v = w_sum_in[49:18];
            RGN_MIDDLE: w_v = w_sum_mid[60:29];
            default:    w_v = w_sum_out[58:27];
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_v      <= w_v;
        r_v_side <= '{neg: r_sq_side.neg, rgn: r_sq_side.rgn, mag: r_sq_side.mag,
                      r: r_sq_side.r, w: w_sum_w[63:32]};
    end

    // Horner pair, two stages per step
    logic [55:0] r_h1_nhi  [HORNER_STEPS];
    logic [63:0] r_h1_nlo  [HORNER_STEPS];
    logic        r_h1_nneg [HORNER_STEPS];
    logic [55:0] r_h1_dhi  [HORNER_STEPS];
    logic [63:0] r_h1_dlo  [HORNER_STEPS];
    logic        r_h1_dneg [HORNER_STEPS];
    logic [31:0] r_h1_v    [HORNER_STEPS];
    t_side       r_h1_side [HORNER_STEPS];
    t_acc        r_h2_num  [HORNER_STEPS];
    t_acc        r_h2_den  [HORNER_STEPS];
    logic [31:0] r_h2_v    [HORNER_STEPS];
    t_side       r_h2_side [HORNER_STEPS];

    for (genvar s = 0; s < HORNER_STEPS; s++) begin : g_hs
        t_acc        a_num;
        t_acc        a_den;
        logic [31:0] a_v;
        t_side       a_side;
        logic [55:0] ua_num;
        logic [55:0] ua_den;

        if (s == 0) begin : g_first
            assign a_num  = num_coef(r_v_side.rgn, COEF_CNT - 1);
            assign a_den  = den_coef(r_v_side.rgn, COEF_CNT - 1);
            assign a_v    = r_v;
            assign a_side = r_v_side;
        end else begin : g_next
            assign a_num  = r_h2_num[s-1];
            assign a_den  = r_h2_den[s-1];
            assign a_v    = r_h2_v[s-1];
            assign a_side = r_h2_side[s-1];
        end

        assign ua_num = acc_abs(a_num);
        assign ua_den = acc_abs(a_den);

        always_ff @(posedge i_clk) begin
            r_h1_nhi[s]  <= ua_num[55:32] * a_v;
            r_h1_nlo[s]  <= ua_num[31:0] * a_v;
            r_h1_nneg[s] <= a_num[ACC_BITS-1];
            r_h1_dhi[s]  <= ua_den[55:32] * a_v;
            r_h1_dlo[s]  <= ua_den[31:0] * a_v;
            r_h1_dneg[s] <= a_den[ACC_BITS-1];
            r_h1_v[s]    <= a_v;
            r_h1_side[s] <= a_side;
        end

        always_ff @(posedge i_clk) begin
            r_h2_num[s]  <= q32_finish(r_h1_nhi[s], r_h1_nlo[s], r_h1_nneg[s],
                                       num_coef(r_h1_side[s].rgn, HORNER_STEPS - 1 - s));
            r_h2_den[s]  <= q32_finish(r_h1_dhi[s], r_h1_dlo[s], r_h1_dneg[s],
                                       den_coef(r_h1_side[s].rgn, HORNER_STEPS - 1 - s));
            r_h2_v[s]    <= r_h1_v[s];
            r_h2_side[s] <= r_h1_side[s];
        end
    end

    // quotient setup: magnitudes, sign, cap on integer part >= 2^20 or zero divisor
    t_acc        w_n;
    t_acc        w_d;
    logic [55:0] w_un;
    logic [55:0] w_ud;
    logic        w_dzero;
    logic        w_qneg;
    logic        w_cap;
    logic [55:0] r_pr_rem;
    logic [51:0] r_pr_feed;
    logic [55:0] r_pr_den;
    t_qside      r_pr_side;

    assign w_n     = r_h2_num[HORNER_STEPS-1];
    assign w_d     = r_h2_den[HORNER_STEPS-1];
    assign w_un    = acc_abs(w_n);
    assign w_ud    = acc_abs(w_d);
    assign w_dzero = (w_ud == 56'd0);
    assign w_qneg  = w_n[ACC_BITS-1] ^ w_d[ACC_BITS-1];
    assign w_cap   = w_dzero || ({20'd0, w_un} >= {w_ud, 20'd0});

    always_ff @(posedge i_clk) begin
        r_pr_rem         <= {20'd0, w_un[55:20]};
        r_pr_feed        <= {w_un[19:0], 32'd0};
        r_pr_den         <= w_ud;
        r_pr_side.s      <= r_h2_side[HORNER_STEPS-1];
        r_pr_side.qneg   <= w_qneg;
        r_pr_side.cap    <= w_cap;
        r_pr_side.capneg <= w_dzero ? w_n[ACC_BITS-1] : w_qneg;
    end

    logic [51:0] w_qb_quo;
    logic [55:0] w_qb_rem;
    logic [55:0] w_qb_den;
    t_qside      w_qb_side;

    dia_divider #(
        .DW(ACC_BITS),
        .QW(QUO_BITS),
        .SW($bits(t_qside))
    ) u_quo (
        .i_clk  (i_clk),
        .i_rem  (r_pr_rem),
        .i_feed (r_pr_feed),
        .i_den  (r_pr_den),
        .i_side (r_pr_side),
        .o_quo  (w_qb_quo),
        .o_rem  (w_qb_rem),
        .o_den  (w_qb_den),
        .o_side (w_qb_side)
    );

    // round quotient, apply cap
    logic        w_rnd;
    logic [52:0] r_qmag;
    logic        r_qsgn;
    t_side       r_q_side;

    assign w_rnd = ({w_qb_rem, 1'b0} >= {1'b0, w_qb_den});

    always_ff @(posedge i_clk) begin
        r_qmag   <= w_qb_side.cap ? (53'd1 << QUO_BITS) : ({1'b0, w_qb_quo} + 53'(w_rnd));
        r_qsgn   <= w_qb_side.cap ? w_qb_side.capneg : w_qb_side.qneg;
        r_q_side <= w_qb_side.s;
    end

    // tail 1: inner ratio clamp, q*w partial products
    logic [33:0] w_ratio;
    logic [52:0] r_p1_hi;
    logic [63:0] r_p1_lo;
    logic        r_p1_neg;
    logic [33:0] r_p1_ratio;
    t_side       r_p1_side;

    always_comb begin
        if (r_qsgn || (r_qmag == 53'd0)) begin
            w_ratio = 34'd0;
        end else if (r_qmag > (53'd1 << 33)) begin
            w_ratio = 34'd1 << 33;
        end else begin
            w_ratio = r_qmag[33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_hi    <= r_qmag[52:32] * r_q_side.w;
        r_p1_lo    <= r_qmag[31:0] * r_q_side.w;
        r_p1_neg   <= r_qsgn;
        r_p1_ratio <= w_ratio;
        r_p1_side  <= r_q_side;
    end

    // tail 2: F = 1 + q*w, clamped; select multiplier operands
    logic [64:0] w_p1_lor;
    logic [53:0] w_p1_m;
    logic signed [55:0] w_f;
    logic [33:0] w_fc;
    logic [31:0] r_p2_a;
    logic [33:0] r_p2_b;
    logic        r_p2_inner;
    logic        r_p2_neg;

    assign w_p1_lor = {1'b0, r_p1_lo} + 65'h0_8000_0000;
    assign w_p1_m   = 54'(r_p1_hi) + 54'(w_p1_lor[64:32]);
    assign w_f      = (56'sd1 <<< 32) + (r_p1_neg ? -56'(w_p1_m) : 56'(w_p1_m));

    always_comb begin
        if (w_f < 56'sd0) begin
            w_fc = 34'd0;
        end else if (w_f > (56'sd1 <<< 33)) begin
            w_fc = 34'd1 << 33;
        end else begin
            w_fc = w_f[33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_side.rgn == RGN_INNER) begin
            r_p2_a <= r_p1_side.mag;
            r_p2_b <= r_p1_ratio;
        end else begin
            r_p2_a <= r_p1_side.r;
            r_p2_b <= w_fc;
        end
        r_p2_inner <= (r_p1_side.rgn == RGN_INNER);
        r_p2_neg   <= r_p1_side.neg;
    end

    // tail 3: final product
    logic [65:0] r_p3_prod;
    logic        r_p3_inner;
    logic        r_p3_neg;

    always_ff @(posedge i_clk) begin
        r_p3_prod  <= r_p2_a * r_p2_b;
        r_p3_inner <= r_p2_inner;
        r_p3_neg   <= r_p2_neg;
    end

    // rounding shift, saturation, sign
    logic [66:0] w_ysum;
    logic [41:0] w_y;
    logic [30:0] w_ys;

    assign w_ysum = {1'b0, r_p3_prod} + (r_p3_inner ? (67'd1 << 24) : (67'd1 << 34));
    assign w_y    = r_p3_inner ? w_ysum[66:25] : {10'd0, w_ysum[66:35]};
    assign w_ys   = (w_y > {11'd0, OUT_MAX}) ? OUT_MAX : w_y[30:0];
    assign o_value = r_p3_neg ? -w_ys : w_ys;

endmodule

// ===== test/dawson_integral_approx_test.sv =====
// Self-checking testbench for dawson_integral_approx: directed table, then random items.
// Depends on dia_pkg (region enum, interval limits) and the dawson_integral_approx RTL.
`timescale 1ns / 100ps

module dawson_integral_approx_test;
    import dia_pkg::*;

    typedef bit [3:0][30:0] t_lane_vals;

    typedef struct {
        bit [31:0]  arg [4];
        bit         typed;
        t_lane_vals vals;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] arg0, arg1, arg2, arg3;
    logic               o_strobe;
    logic signed [30:0] o_value_lane0, o_value_lane1, o_value_lane2, o_value_lane3;

    t_lane_vals         dawson_queue [$];
    longint             num_q [3][11];
    longint             den_q [3][11];
    int                 mismatches;

    dawson_integral_approx #(.LANES(4)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_arg_lane0   (arg0),
        .i_arg_lane1   (arg1),
        .i_arg_lane2   (arg2),
        .i_arg_lane3   (arg3),
        .o_strobe      (o_strobe),
        .o_value_lane0 (o_value_lane0),
        .o_value_lane1 (o_value_lane1),
        .o_value_lane2 (o_value_lane2),
        .o_value_lane3 (o_value_lane3)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Decimal mantissa * 10^-dexp scaled to round(value * 2^g).
    function automatic longint coef_fixed(input longint man, input int dexp, input int g);
        bit        neg;
        bit [63:0] x;
        int        p;
        neg = man < 0;
        x   = neg ? 64'(-man) : 64'(man);
        p   = g;
        if (x == 0) return 0;
        for (int i = 0; i < dexp; i++) begin
            while (x < 64'h0800_0000_0000_0000) begin
                x = x << 1;
                p--;
            end
            x = x / 64'd10;
        end
        if (p < 0) begin
            if (-p >= 63) x = 0;
            else x = (x + (64'd1 << (-p - 1))) >> (-p);
        end else begin
            x = x << p;
        end
        return neg ? -longint'(x) : longint'(x);
    endfunction

    task automatic load_num(input t_region rg, input int k, input longint man, input int dexp);
        int g;
        g = (rg == RGN_INNER) ? 40 + 4 * k : (rg == RGN_MIDDLE) ? 64 - 3 * k : 48 - 5 * k;
        num_q[int'(rg)][k] = coef_fixed(man, dexp, g);
    endtask

    task automatic load_den(input t_region rg, input int k, input longint man, input int dexp);
        int g;
        g = (rg == RGN_INNER) ? 40 + 4 * k : (rg == RGN_MIDDLE) ? 64 - 3 * k : 48 - 5 * k;
        den_q[int'(rg)][k] = coef_fixed(man, dexp, g);
    endtask

    // Signed accumulator times Q0.32 variable, rounded on the magnitude.
    function automatic longint mul_frac(input longint a, input bit [63:0] v);
        bit [63:0] ua, hi, lo, r;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        hi = (ua >> 32) * v;
        lo = (ua & 64'hFFFF_FFFF) * v;
        r  = hi + ((lo + 64'h8000_0000) >> 32);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    // Q32 quotient, integer part capped at 2^20.
    function automatic longint quot_q32(input longint n, input longint d);
        bit        neg;
        bit [63:0] un, ud, q, r;
        longint    cap;
        cap = longint'(1) << 52;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? 64'(-n) : 64'(n);
        ud  = (d < 0) ? 64'(-d) : 64'(d);
        if (ud == 0) return (n < 0) ? -cap : cap;
        q = un / ud;
        if (q >= (64'd1 << 20)) return neg ? -cap : cap;
        r = un % ud;
        for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= ud) q++;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint poly_eval(input t_region rg, input bit den, input int cnt,
                                         input bit [63:0] v);
        longint acc;
        acc = den ? den_q[int'(rg)][cnt-1] : num_q[int'(rg)][cnt-1];
        for (int k = cnt - 2; k >= 0; k--) begin
            acc = mul_frac(acc, v) + (den ? den_q[int'(rg)][k] : num_q[int'(rg)][k]);
        end
        return acc;
    endfunction

    function automatic bit [30:0] dawson_fixed(input bit [31:0] arg);
        bit        neg;
        bit [63:0] mag, u, r, sq, w, v, y;
        longint    n, d, ratio, f, top;
        neg = arg[31];
        mag = neg ? (64'h1_0000_0000 - 64'(arg)) : 64'(arg);
        top = longint'(1) << 33;
        if (mag < 64'(LIM_INNER)) begin
            // x * P(s)/Q(s), variable s/16 in Q0.32
            u     = (mag * mag + (64'd1 << 17)) >> 18;
            n     = poly_eval(RGN_INNER, 1'b0, 10, u);
            d     = poly_eval(RGN_INNER, 1'b1, 11, u);
            ratio = quot_q32(n, d);
            if (ratio < 0) ratio = 0;
            if (ratio > top) ratio = top;
            y = (mag * 64'(ratio) + (64'd1 << 24)) >> 25;
        end else begin
            // asymptotic form in 1/x
            r  = ((64'd1 << 55) + (mag >> 1)) / mag;
            sq = r * r;
            w  = (sq + (64'd1 << 31)) >> 32;
            if (mag < 64'(LIM_MIDDLE)) begin
                v = (sq + (64'd1 << 28)) >> 29;
                n = poly_eval(RGN_MIDDLE, 1'b0, 11, v);
                d = poly_eval(RGN_MIDDLE, 1'b1, 11, v);
            end else begin
                v = (sq + (64'd1 << 26)) >> 27;
                n = poly_eval(RGN_OUTER, 1'b0, 5, v);
                d = poly_eval(RGN_OUTER, 1'b1, 6, v);
            end
            f = (longint'(1) << 32) + mul_frac(quot_q32(n, d), w);
            if (f < 0) f = 0;
            if (f > top) f = top;
            y = (r * 64'(f) + (64'd1 << 34)) >> 35;
        end
        if (y > 64'(OUT_MAX)) y = 64'(OUT_MAX);
        return neg ? 31'(-y) : 31'(y);
    endfunction

    // Drive one item at the falling edge; it is taken at the next rising edge with busy low.
    task automatic issue(input bit [31:0] a0, a1, a2, a3, input bit typed,
                         input t_lane_vals vals);
        t_lane_vals exp_vals;
        @(negedge i_clk);
        start <= 1'b1;
        arg0  <= a0;
        arg1  <= a1;
        arg2  <= a2;
        arg3  <= a3;
        while (busy) @(negedge i_clk);
        if (typed) begin
            exp_vals = vals;
        end else begin
            exp_vals[0] = dawson_fixed(a0);
            exp_vals[1] = dawson_fixed(a1);
            exp_vals[2] = dawson_fixed(a2);
            exp_vals[3] = dawson_fixed(a3);
        end
        dawson_queue.push_back(exp_vals);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
        arg0  <= $urandom;
        arg1  <= $urandom;
    endtask

    // Random argument, biased toward each interval and its edges.
    function automatic bit [31:0] rand_arg();
        bit [31:0] x;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: x = $urandom_range(0, LIM_INNER - 1);
            2: x = $urandom_range(LIM_INNER, LIM_MIDDLE - 1);
            3: x = $urandom_range(LIM_MIDDLE, 32'h7FFF_FFFF);
            4: x = ($urandom_range(0, 1) ? LIM_INNER : LIM_MIDDLE) + $urandom_range(0, 8) - 4;
            default: x = $urandom_range(0, 32'h0001_0000);
        endcase
        return $urandom_range(0, 1) ? -x : x;
    endfunction

    // Result check: one strobe, compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_lane_vals got, want;
        if (i_rst_n && o_strobe) begin
            got = {o_value_lane3, o_value_lane2, o_value_lane1, o_value_lane0};
            if (dawson_queue.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = dawson_queue.pop_front();
                for (int l = 0; l < 4; l++) begin
                    if (got[l] !== want[l])
                        report($sformatf("lane %0d got %h want %h", l, got[l], want[l]));
                end
            end
        end
    end

    initial begin
        t_stim_row  rows [$];
        t_stim_row  row;
        int         pct;
        int         waited;
        mismatches = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        arg0       = '0;
        arg1       = '0;
        arg2       = '0;
        arg3       = '0;

        load_num(RGN_INNER, 0, 64'sd1000000000, 9);
        load_num(RGN_INNER, 1, -64'sd9174803718, 11);
        load_num(RGN_INNER, 2, 64'sd4226182230, 11);
        load_num(RGN_INNER, 3, -64'sd8501498467, 13);
        load_num(RGN_INNER, 4, 64'sd3525133685, 13);
        load_num(RGN_INNER, 5, 64'sd3078283099, 15);
        load_num(RGN_INNER, 6, 64'sd9531517413, 16);
        load_num(RGN_INNER, 7, 64'sd1944342042, 17);
        load_num(RGN_INNER, 8, 64'sd8492622677, 19);
        load_num(RGN_INNER, 9, 64'sd1136814990, 20);
        load_den(RGN_INNER, 0, 64'sd1000000000, 9);
        load_den(RGN_INNER, 1, 64'sd5749186295, 10);
        load_den(RGN_INNER, 2, 64'sd1588742420, 10);
        load_den(RGN_INNER, 3, 64'sd2794485312, 11);
        load_den(RGN_INNER, 4, 64'sd3488058147, 12);
        load_den(RGN_INNER, 5, 64'sd3255247418, 13);
        load_den(RGN_INNER, 6, 64'sd2324902498, 14);
        load_den(RGN_INNER, 7, 64'sd1272584783, 15);
        load_den(RGN_INNER, 8, 64'sd5212652810, 17);
        load_den(RGN_INNER, 9, 64'sd1488646814, 18);
        load_den(RGN_INNER, 10, 64'sd2403720731, 20);
        load_num(RGN_MIDDLE, 0, 64'sd3592333854, 20);
        load_num(RGN_MIDDLE, 1, -64'sd2402745208, 18);
        load_num(RGN_MIDDLE, 2, 64'sd9100107801, 17);
        load_num(RGN_MIDDLE, 3, -64'sd2146403517, 15);
        load_num(RGN_MIDDLE, 4, 64'sd3596413048, 14);
        load_num(RGN_MIDDLE, 5, -64'sd4232091145, 13);
        load_num(RGN_MIDDLE, 6, 64'sd3662076123, 12);
        load_num(RGN_MIDDLE, 7, -64'sd2187112551, 11);
        load_num(RGN_MIDDLE, 8, 64'sd9415123353, 11);
        load_num(RGN_MIDDLE, 9, -64'sd2447544181, 10);
        load_num(RGN_MIDDLE, 10, 64'sd5089551564, 10);
        load_den(RGN_MIDDLE, 0, 64'sd7184664032, 20);
        load_den(RGN_MIDDLE, 1, -64'sd4913246913, 18);
        load_den(RGN_MIDDLE, 2, 64'sd1891003581, 16);
        load_den(RGN_MIDDLE, 3, -64'sd4558751533, 15);
        load_den(RGN_MIDDLE, 4, 64'sd7810255929, 14);
        load_den(RGN_MIDDLE, 5, -64'sd9479967685, 13);
        load_den(RGN_MIDDLE, 6, 64'sd8480417186, 12);
        load_den(RGN_MIDDLE, 7, -64'sd5318063670, 11);
        load_den(RGN_MIDDLE, 8, 64'sd2367067882, 10);
        load_den(RGN_MIDDLE, 9, -64'sd6318398699, 10);
        load_den(RGN_MIDDLE, 10, 64'sd1000000000, 9);
        load_num(RGN_OUTER, 0, -64'sd4868276130, 13);
        load_num(RGN_OUTER, 1, 64'sd1648370478, 11);
        load_num(RGN_OUTER, 2, -64'sd1728589754, 10);
        load_num(RGN_OUTER, 3, 64'sd6292352427, 10);
        load_num(RGN_OUTER, 4, -64'sd5905928605, 10);
        load_den(RGN_OUTER, 0, -64'sd9736552260, 13);
        load_den(RGN_OUTER, 1, 64'sd3442789240, 11);
        load_den(RGN_OUTER, 2, -64'sd3937085823, 10);
        load_den(RGN_OUTER, 3, 64'sd1732707990, 9);
        load_den(RGN_OUTER, 4, -64'sd2698200572, 9);
        load_den(RGN_OUTER, 5, 64'sd1000000000, 9);

        // Directed rows: zero reads off as zero; everything else goes through the predictor.
        rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '0});
        rows.push_back('{'{32'h1, 32'hFFFF_FFFF, 32'h0080_0000, 32'hFF80_0000}, 1'b0, '0});
        rows.push_back('{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0}, 1'b0, '0});
        rows.push_back('{'{LIM_INNER - 1, LIM_INNER, -LIM_INNER, -(LIM_INNER - 1)}, 1'b0, '0});
        rows.push_back('{'{LIM_MIDDLE - 1, LIM_MIDDLE, -LIM_MIDDLE, -(LIM_MIDDLE - 1)},
                         1'b0, '0});
        rows.push_back('{'{32'h0076_6666, 32'hFF89_999A, 32'h0040_0000, 32'h0200_0000},
                         1'b0, '0});
        rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000},
                         1'b0, '0});
        rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '0});

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            issue(row.arg[0], row.arg[1], row.arg[2], row.arg[3], row.typed, row.vals);
        end

        // Random: sender gaps at 7%, then 45%, then none.
        for (int ph = 0; ph < 3; ph++) begin
            pct = (ph == 0) ? 7 : (ph == 1) ? 45 : 0;
            for (int n = 0; n < 400; n++) begin
                while ($urandom_range(0, 99) < pct) idle_cycle();
                issue(rand_arg(), rand_arg(), rand_arg(), rand_arg(), 1'b0, '0);
            end
        end
        @(negedge i_clk);
        start <= 1'b0;

        waited = 0;
        while (dawson_queue.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LANE_LAT + 8) @(posedge i_clk);
        if (dawson_queue.size() != 0)
            report($sformatf("%0d results never arrived", dawson_queue.size()));

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
